FILE: design/gn3o_pkg.sv
// Shared types, constants and arithmetic helpers for the 3D gradient noise block.
// Used by the controller, the datapath, the top level and the checker.
package gn3o_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int VAL_W      = 26;
   localparam int ACC_EXTRA  = 31;
   localparam int ACC_W      = 53;
   localparam int OUT_W      = 20;
   localparam int IDX_W      = 8;
   localparam int TABLE_SIZE = 256;
   localparam int OCT_W      = 5;
   localparam int COORD_W    = 32;
   localparam int MODE_W     = 2;
   localparam int STEP_W     = 5;

   typedef logic signed [VAL_W-1:0]   val_type;
   typedef logic signed [2*VAL_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   localparam val_type ONE      = val_type'(64'sd1 << FRAC_BITS);
   localparam val_type TEN_ONE  = val_type'(64'sd10 << FRAC_BITS);
   localparam val_type FIFT_ONE = val_type'(64'sd15 << FRAC_BITS);
   localparam acc_type OUT_MAX  = acc_type'((64'sd1 << (OUT_W - 1)) - 64'sd1);
   localparam acc_type OUT_MIN  = acc_type'(-(64'sd1 << (OUT_W - 1)));

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD    = 2'd0,
      MODE_SAMPLE  = 2'd1,
      MODE_FRACTAL = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_RUN,
      CS_OUT
   } ctrl_state_type;

   typedef enum logic [STEP_W-1:0] {
      ST_R0  = 5'd0,
      ST_R1  = 5'd1,
      ST_R2  = 5'd2,
      ST_R3  = 5'd3,
      ST_R4  = 5'd4,
      ST_R5  = 5'd5,
      ST_R6  = 5'd6,
      ST_R7  = 5'd7,
      ST_R8  = 5'd8,
      ST_R9  = 5'd9,
      ST_R10 = 5'd10,
      ST_R11 = 5'd11,
      ST_R12 = 5'd12,
      ST_R13 = 5'd13,
      ST_R14 = 5'd14,
      ST_LA  = 5'd15,
      ST_LB  = 5'd16,
      ST_LC  = 5'd17,
      ST_LD  = 5'd18,
      ST_LE  = 5'd19,
      ST_LF  = 5'd20,
      ST_LG  = 5'd21,
      ST_ACC = 5'd22,
      ST_NOP = 5'd23
   } step_type;

   typedef struct packed {
      logic             load;
      logic             zero_z;
      logic             clear_acc;
      logic             mem_we;
      logic             run;
      step_type         step;
      logic             dbl;
      logic [OCT_W-1:0] octave;
      logic             out_load;
   } dp_cmd_type;

   // Shift a product back to the working fraction, rounding half up.
   function automatic val_type round_frac(input prod_type p);
      prod_type w;
      w = p + (prod_type'(1) <<< (FRAC_BITS - 1));
      return val_type'(w >>> FRAC_BITS);
   endfunction

   function automatic val_type grad(input logic [3:0] h, input val_type dx,
                                    input val_type dy, input val_type dz);
      val_type u;
      val_type v;
      val_type su;
      val_type sv;
      u  = (h < 4'd8) ? dx : dy;
      v  = (h < 4'd4) ? dy : ((h == 4'd12 || h == 4'd14) ? dx : dz);
      su = h[0] ? -u : u;
      sv = h[1] ? -v : v;
      return su + sv;
   endfunction

endpackage

FILE: design/gradient_noise_3d_octave_top.sv
// Top level of the improved 3D gradient noise block with 2D octave sums.
// Instantiates gn3o_ctrl and gn3o_dp; depends on gn3o_pkg.
//
// Coordinates are signed Q16.16 and the result is signed Q3.16, saturated. The
// permutation table is loaded by software one entry per transaction in load mode,
// which returns nothing and does not hold off the next request; every entry must
// be loaded before it is read. A sample transaction returns one result. One noise
// evaluation is paced by the single table read port (14 chained reads) followed
// by seven blends on the one shared multiplier. A fractal transaction runs one
// evaluation per octave, and returns zero when the octave count is zero. One
// transaction is worked on at a time; a new one is taken while the previous
// result still waits in the output register.
module gradient_noise_3d_octave_top import gn3o_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic signed [COORD_W-1:0] req_x_coord,
   input  logic signed [COORD_W-1:0] req_y_coord,
   input  logic signed [COORD_W-1:0] req_z_coord,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic [IDX_W-1:0]        req_entry_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_noise_value,
   input  logic                    csr_wr_en,
   input  logic [OCT_W-1:0]        csr_wr_data
);

   dp_cmd_type cmd;

   gn3o_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_mode    (req_mode),
      .req_stall   (req_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd)
   );

   gn3o_dp u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_z_coord     (req_z_coord),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule

FILE: design/gn3o_ctrl.sv
// Controller for the gradient noise block: transaction handshake, step sequencer,
// octave loop and the octave count register. Depends on gn3o_pkg.
module gn3o_ctrl import gn3o_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_stall,
   input  logic              csr_wr_en,
   input  logic [OCT_W-1:0]  csr_wr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dp_cmd_type        cmd
);

   ctrl_state_type   state_ff, state_in;
   step_type         step_ff, step_in;
   logic [OCT_W-1:0] k_ff, k_in;
   logic [OCT_W-1:0] count_ff;
   logic             fractal_ff, fractal_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign accept    = req_valid && (state_ff == CS_IDLE);
   assign req_stall = (state_ff != CS_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         step_ff      <= ST_NOP;
         k_ff         <= '0;
         fractal_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= OCT_W'(1);
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         k_ff         <= k_in;
         fractal_ff   <= fractal_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      k_in         = k_ff;
      fractal_in   = fractal_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.step     = ST_NOP;
      cmd.octave   = k_ff;
      case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_LOAD: begin
                     cmd.mem_we = 1'b1;
                  end
                  MODE_SAMPLE: begin
                     cmd.load      = 1'b1;
                     cmd.clear_acc = 1'b1;
                     k_in          = '0;
                     fractal_in    = 1'b0;
                     step_in       = ST_R0;
                     state_in      = CS_RUN;
                  end
                  MODE_FRACTAL: begin
                     cmd.load      = 1'b1;
                     cmd.zero_z    = 1'b1;
                     cmd.clear_acc = 1'b1;
                     k_in          = '0;
                     fractal_in    = 1'b1;
                     step_in       = ST_R0;
                     state_in      = (count_ff == '0) ? CS_OUT : CS_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         CS_RUN: begin
            cmd.run  = 1'b1;
            cmd.step = step_ff;
            if (step_ff == ST_ACC) begin
               if (fractal_ff && ((6'(k_ff) + 6'd1) < 6'(count_ff))) begin
                  cmd.dbl = 1'b1;
                  k_in    = k_ff + OCT_W'(1);
                  step_in = ST_R0;
               end else begin
                  state_in = CS_OUT;
               end
            end else begin
               step_in = step_type'(step_ff + STEP_W'(1));
            end
         end
         CS_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

FILE: design/gn3o_dp.sv
// Datapath for the gradient noise block: permutation table memory, hash chain,
// shared multiplier for fade and blends, octave accumulator. Depends on gn3o_pkg.
module gn3o_dp import gn3o_pkg::*; (
   input  logic                    clock,
   input  dp_cmd_type              cmd,
   input  logic [COORD_W-1:0]      req_x_coord,
   input  logic [COORD_W-1:0]      req_y_coord,
   input  logic [COORD_W-1:0]      req_z_coord,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic [IDX_W-1:0]        req_entry_value,
   output logic signed [OUT_W-1:0] rsp_noise_value
);

   logic [IDX_W-1:0]   perm_mem [0:TABLE_SIZE-1];
   logic [IDX_W-1:0]   rd_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic [IDX_W-1:0]   a_ff, b_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic [3:0]         h_ff [0:7];
   val_type            fu_ff, fv_ff, fw_ff, p2_ff, t2_ff, t3_ff;
   val_type            l0_ff, l1_ff, l2_ff, l3_ff, m0_ff, m1_ff, n_ff;
   acc_type            acc_ff;
   logic signed [OUT_W-1:0] out_ff;

   logic [IDX_W-1:0] xi, yi, zi;
   val_type          fx, fy, fz, x1, y1, z1;
   val_type          t, ga, gb, mul_a, mul_b, base, sum, clamped;
   prod_type         prod;
   acc_type          rounded;
   logic [OCT_W-1:0] shamt;

   assign xi = x_ff[COORD_W-9:COORD_W-16];
   assign yi = y_ff[COORD_W-9:COORD_W-16];
   assign zi = z_ff[COORD_W-9:COORD_W-16];
   assign fx = {{(VAL_W-16){1'b0}}, x_ff[15:0]};
   assign fy = {{(VAL_W-16){1'b0}}, y_ff[15:0]};
   assign fz = {{(VAL_W-16){1'b0}}, z_ff[15:0]};
   assign x1 = fx - ONE;
   assign y1 = fy - ONE;
   assign z1 = fz - ONE;

   always_comb begin
      case (cmd.step)
         ST_R0:   rd_addr = xi;
         ST_R1:   rd_addr = xi + IDX_W'(1);
         ST_R2:   rd_addr = a_ff;
         ST_R3:   rd_addr = a_ff + IDX_W'(1);
         ST_R4:   rd_addr = b_ff;
         ST_R5:   rd_addr = b_ff + IDX_W'(1);
         ST_R6:   rd_addr = aa_ff;
         ST_R7:   rd_addr = ba_ff;
         ST_R8:   rd_addr = ab_ff;
         ST_R9:   rd_addr = bb_ff;
         ST_R10:  rd_addr = aa_ff + IDX_W'(1);
         ST_R11:  rd_addr = ba_ff + IDX_W'(1);
         ST_R12:  rd_addr = ab_ff + IDX_W'(1);
         ST_R13:  rd_addr = bb_ff + IDX_W'(1);
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         perm_mem[req_entry_index] <= req_entry_value;
      end
      rd_ff <= perm_mem[rd_addr];
   end

   always_comb begin
      case (cmd.step)
         ST_R0, ST_R1, ST_R2, ST_R3: t = fx;
         ST_R4, ST_R5, ST_R6, ST_R7: t = fy;
         default:                    t = fz;
      endcase
      ga    = '0;
      gb    = '0;
      mul_a = '0;
      mul_b = '0;
      base  = '0;
      case (cmd.step)
         ST_R0, ST_R4, ST_R8: begin
            mul_a = t;
            mul_b = (t <<< 2) + (t <<< 1) - FIFT_ONE;
            base  = TEN_ONE;
         end
         ST_R1, ST_R5, ST_R9: begin
            mul_a = t;
            mul_b = t;
         end
         ST_R2, ST_R6, ST_R10: begin
            mul_a = t2_ff;
            mul_b = t;
         end
         ST_R3, ST_R7, ST_R11: begin
            mul_a = t3_ff;
            mul_b = p2_ff;
         end
         ST_LA: begin
            ga = grad(h_ff[0], fx, fy, fz);
            gb = grad(h_ff[1], x1, fy, fz);
         end
         ST_LB: begin
            ga = grad(h_ff[2], fx, y1, fz);
            gb = grad(h_ff[3], x1, y1, fz);
         end
         ST_LC: begin
            ga = grad(h_ff[4], fx, fy, z1);
            gb = grad(h_ff[5], x1, fy, z1);
         end
         ST_LD: begin
            ga = grad(h_ff[6], fx, y1, z1);
            gb = grad(h_ff[7], x1, y1, z1);
         end
         ST_LE: begin
            mul_a = fv_ff;
            mul_b = l1_ff - l0_ff;
            base  = l0_ff;
         end
         ST_LF: begin
            mul_a = fv_ff;
            mul_b = l3_ff - l2_ff;
            base  = l2_ff;
         end
         ST_LG: begin
            mul_a = fw_ff;
            mul_b = m1_ff - m0_ff;
            base  = m0_ff;
         end
         default: begin
         end
      endcase
      if (cmd.step == ST_LA || cmd.step == ST_LB || cmd.step == ST_LC ||
          cmd.step == ST_LD) begin
         mul_a = fu_ff;
         mul_b = gb - ga;
         base  = ga;
      end
      prod = prod_type'(mul_a) * prod_type'(mul_b);
      sum  = base + round_frac(prod);
      if (sum < 0) begin
         clamped = '0;
      end else if (sum > ONE) begin
         clamped = ONE;
      end else begin
         clamped = sum;
      end
      shamt   = OCT_W'(ACC_EXTRA) - cmd.octave;
      rounded = (acc_ff + (acc_type'(1) <<< (ACC_EXTRA - 1))) >>> ACC_EXTRA;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_x_coord;
         y_ff <= req_y_coord;
         z_ff <= cmd.zero_z ? '0 : req_z_coord;
      end else if (cmd.dbl) begin
         x_ff <= {x_ff[COORD_W-2:0], 1'b0};
         y_ff <= {y_ff[COORD_W-2:0], 1'b0};
      end
      if (cmd.clear_acc) begin
         acc_ff <= '0;
      end
      if (cmd.run) begin
         case (cmd.step)
            ST_R0:  p2_ff <= sum;
            ST_R1: begin
               a_ff  <= rd_ff + yi;
               t2_ff <= sum;
            end
            ST_R2: begin
               b_ff  <= rd_ff + yi;
               t3_ff <= sum;
            end
            ST_R3: begin
               aa_ff <= rd_ff + zi;
               fu_ff <= clamped;
            end
            ST_R4: begin
               ab_ff <= rd_ff + zi;
               p2_ff <= sum;
            end
            ST_R5: begin
               ba_ff <= rd_ff + zi;
               t2_ff <= sum;
            end
            ST_R6: begin
               bb_ff <= rd_ff + zi;
               t3_ff <= sum;
            end
            ST_R7: begin
               h_ff[0] <= rd_ff[3:0];
               fv_ff   <= clamped;
            end
            ST_R8: begin
               h_ff[1] <= rd_ff[3:0];
               p2_ff   <= sum;
            end
            ST_R9: begin
               h_ff[2] <= rd_ff[3:0];
               t2_ff   <= sum;
            end
            ST_R10: begin
               h_ff[3] <= rd_ff[3:0];
               t3_ff   <= sum;
            end
            ST_R11: begin
               h_ff[4] <= rd_ff[3:0];
               fw_ff   <= clamped;
            end
            ST_R12: h_ff[5] <= rd_ff[3:0];
            ST_R13: h_ff[6] <= rd_ff[3:0];
            ST_R14: h_ff[7] <= rd_ff[3:0];
            ST_LA:  l0_ff <= sum;
            ST_LB:  l1_ff <= sum;
            ST_LC:  l2_ff <= sum;
            ST_LD:  l3_ff <= sum;
            ST_LE:  m0_ff <= sum;
            ST_LF:  m1_ff <= sum;
            ST_LG:  n_ff  <= sum;
            ST_ACC: acc_ff <= acc_ff + (acc_type'(n_ff) <<< shamt);
            default: begin
            end
         endcase
      end
      if (cmd.out_load) begin
         if (rounded > OUT_MAX) begin
            out_ff <= OUT_W'(OUT_MAX);
         end else if (rounded < OUT_MIN) begin
            out_ff <= OUT_W'(OUT_MIN);
         end else begin
            out_ff <= OUT_W'(rounded);
         end
      end
   end

   assign rsp_noise_value = out_ff;

endmodule

FILE: design/gn3o_checker.sv
// Port-level checker for the gradient noise block, bound to the top level.
// Depends on gn3o_pkg.
module gn3o_checker import gn3o_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [MODE_W-1:0]       req_mode,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [OUT_W-1:0] rsp_noise_value
);

   // A result waiting on a stalled consumer holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("result changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A table load leaves the block ready for the next request.
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_LOAD |=> !req_stall)
      else $error("busy after table load");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_SAMPLE |=> req_stall)
      else $error("not busy after sample transaction");

   a_unused_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_UNUSED |=> !req_stall)
      else $error("busy after unused mode");

endmodule

bind gradient_noise_3d_octave_top gn3o_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_noise_value (rsp_noise_value)
);
